// ===== hw/rtl/acrq_pkg.sv =====
// Shared types and codes for the acknowledgement checkpoint replay queue.
package acrq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 32;

   localparam int PEND_W  = 6;
   localparam int APPLY_W = 8;

   localparam logic [1:0] CMD_ADD        = 2'd0;
   localparam logic [1:0] CMD_CHECKPOINT = 2'd1;
   localparam logic [1:0] CMD_CLEAR      = 2'd2;

   localparam logic [2:0] KIND_APPLIED   = 3'd0;
   localparam logic [2:0] KIND_REAPPLIED = 3'd1;
   localparam logic [2:0] KIND_DROPPED   = 3'd2;
   localparam logic [2:0] KIND_DONE      = 3'd3;
   localparam logic [2:0] KIND_CLEARED   = 3'd4;

   localparam logic [APPLY_W-1:0] APPLY_MAX = '1;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] event_handle;
      logic [31:0] message_id;
   } req_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [15:0]        event_handle_out;
      logic [31:0]        tag_id;
      logic [APPLY_W-1:0] apply_count;
      logic [PEND_W-1:0]  pending_count;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        handle;
      logic [31:0]        tag;
      logic [APPLY_W-1:0] applies;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

endpackage

// ===== hw/rtl/acrq_slot_mem.sv =====
// Slot storage: one write port, one registered read port.
module acrq_slot_mem #(
   parameter int DEPTH = acrq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int IDX_W = 5
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  acrq_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_addr,
   output acrq_pkg::entry_type rd_data
);
   import acrq_pkg::*;

   entry_type slot_mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ack_checkpoint_replay_queue.sv =====
// Add, add-full drop and clear: one registered result in the cycle after acceptance; busy stays low.
// Checkpoint over N stored entries, K surviving: busy through a compaction pass then a replay
// pass, both using the single slot memory read port, each draining its registered read before
// it exits. K reapplied beats, then the done beat in the first idle cycle. Results cannot be held off.
// Synchronous reset empties the queue; slot contents are left as they were.
module ack_checkpoint_replay_queue #(
   parameter int QUEUE_DEPTH = acrq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  acrq_pkg::req_type req,
   output logic              rsp_strobe,
   output acrq_pkg::rsp_type rsp
);
   import acrq_pkg::*;

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0] keep_ff, keep_in;
   logic             pend_ff, pend_in;
   logic [31:0]      ack_id_ff, ack_id_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_type          rsp_ff, rsp_in;

   logic             wr_en, rd_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data, rd_data;
   logic             accept, issue;
   logic [APPLY_W-1:0] bumped;

   acrq_slot_mem #(
      .DEPTH (QUEUE_DEPTH),
      .IDX_W (IDX_W)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign accept = start && (state_ff == ST_IDLE);
   assign issue  = (rd_idx_ff < occ_ff);
   assign bumped = (rd_data.applies == APPLY_MAX) ? APPLY_MAX : rd_data.applies + 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req.command == CMD_CHECKPOINT) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!issue && !pend_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!issue && !pend_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      occ_in        = occ_ff;
      rd_idx_in     = rd_idx_ff;
      keep_in       = keep_ff;
      pend_in       = 1'b0;
      ack_id_in     = ack_id_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = occ_ff[IDX_W-1:0];
      wr_data       = '{handle: req.event_handle, tag: req.message_id,
                        applies: APPLY_W'(1)};
      rd_en         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req.command)
                  CMD_ADD: begin
                     rsp_strobe_in = 1'b1;
                     rsp_in.event_handle_out = req.event_handle;
                     rsp_in.tag_id           = req.message_id;
                     rsp_in.last             = 1'b1;
                     if (occ_ff == DEPTH_CNT) begin
                        rsp_in.kind          = KIND_DROPPED;
                        rsp_in.apply_count   = '0;
                        rsp_in.pending_count = PEND_W'(occ_ff);
                     end else begin
                        wr_en                = 1'b1;
                        occ_in               = occ_ff + 1'b1;
                        rsp_in.kind          = KIND_APPLIED;
                        rsp_in.apply_count   = APPLY_W'(1);
                        rsp_in.pending_count = PEND_W'(occ_ff + 1'b1);
                     end
                  end
                  CMD_CHECKPOINT: begin
                     ack_id_in = req.message_id;
                     rd_idx_in = '0;
                     keep_in   = '0;
                  end
                  CMD_CLEAR: begin
                     occ_in        = '0;
                     rsp_strobe_in = 1'b1;
                     rsp_in        = '{kind: KIND_CLEARED, last: 1'b1, default: '0};
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            // read slot i while compacting the slot read last cycle; keep <= i
            if (issue) begin
               rd_en     = 1'b1;
               rd_idx_in = rd_idx_ff + 1'b1;
               pend_in   = 1'b1;
            end
            if (pend_ff && rd_data.tag > ack_id_ff) begin
               wr_en   = 1'b1;
               wr_addr = keep_ff[IDX_W-1:0];
               wr_data = '{handle: rd_data.handle, tag: rd_data.tag, applies: bumped};
               keep_in = keep_ff + 1'b1;
            end
            if (!issue && !pend_ff) begin
               occ_in    = keep_ff;
               rd_idx_in = '0;
            end
         end
         ST_EMIT: begin
            if (issue) begin
               rd_en     = 1'b1;
               rd_idx_in = rd_idx_ff + 1'b1;
               pend_in   = 1'b1;
            end
            if (pend_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_in = '{kind: KIND_REAPPLIED, event_handle_out: rd_data.handle,
                          tag_id: rd_data.tag, apply_count: rd_data.applies,
                          pending_count: PEND_W'(occ_ff), last: 1'b0};
            end else if (!issue) begin
               rsp_strobe_in = 1'b1;
               rsp_in = '{kind: KIND_DONE, pending_count: PEND_W'(occ_ff), last: 1'b1,
                          default: '0};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         occ_ff        <= '0;
         rd_idx_ff     <= '0;
         keep_ff       <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         occ_ff        <= occ_in;
         rd_idx_ff     <= rd_idx_in;
         keep_ff       <= keep_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      ack_id_ff <= ack_id_in;
      rsp_ff    <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= DEPTH_CNT)
      else $error("occupancy beyond queue depth");

   a_keep_behind: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> keep_ff <= rd_idx_ff)
      else $error("compaction write index ahead of read index");

   a_scan_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> !rsp_strobe)
      else $error("result beat during compaction pass");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp.last |-> !busy)
      else $error("final beat while sequencer still busy");

   a_reapply_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp.kind == KIND_REAPPLIED |-> rsp.apply_count >= APPLY_W'(2))
      else $error("reapplied beat with apply count below two");

endmodule
